// File: rtl/btn_dbnc_pkg.sv
// ----------------------------------------------------------------------------
// btn_dbnc_pkg
// Shared types and constants of the button debouncer with long press and
// auto-repeat.
// ----------------------------------------------------------------------------
package btn_dbnc_pkg;

   localparam int TIME_WIDTH = 32;
   localparam int REG_WIDTH  = 32;
   localparam int CMP_WIDTH  = (TIME_WIDTH > REG_WIDTH) ? TIME_WIDTH : REG_WIDTH;

   localparam int CSR_ADDR_WIDTH = 5;
   localparam int CSR_DATA_WIDTH = 32;

   // register indexes (byte address / 4)
   localparam logic [2:0] REG_ENABLED         = 3'd0;
   localparam logic [2:0] REG_PRESSED_LOW     = 3'd1;
   localparam logic [2:0] REG_DEBOUNCE_TIME   = 3'd2;
   localparam logic [2:0] REG_LONG_PRESS_TIME = 3'd3;
   localparam logic [2:0] REG_REPEAT_INTERVAL = 3'd4;

   // event codes
   localparam logic [2:0] EV_NONE   = 3'd0;
   localparam logic [2:0] EV_DOWN   = 3'd1;
   localparam logic [2:0] EV_CLICK  = 3'd2;
   localparam logic [2:0] EV_LONG   = 3'd3;
   localparam logic [2:0] EV_UP     = 3'd4;
   localparam logic [2:0] EV_REPEAT = 3'd5;

   // debounce phases
   localparam logic [1:0] PH_IDLE  = 2'd0;
   localparam logic [1:0] PH_DEB   = 2'd1;
   localparam logic [1:0] PH_PRESS = 2'd2;
   localparam logic [1:0] PH_LONG  = 2'd3;

   typedef struct packed {
      logic                 enabled;
      logic                 pressed_low;
      logic [REG_WIDTH-1:0] debounce_time;
      logic [REG_WIDTH-1:0] long_press_time;
      logic [REG_WIDTH-1:0] repeat_interval;
      logic                 restart;   // pulse: enable went from 0 to 1
   } cfg_type;

endpackage

// File: rtl/btn_dbnc_csr.sv
// ----------------------------------------------------------------------------
// btn_dbnc_csr
// APB-style configuration registers with the enable restart pulse.
// ----------------------------------------------------------------------------
module btn_dbnc_csr
   import btn_dbnc_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                      csr_pready,
   output cfg_type                   cfg
);

   logic                 enabled_ff;
   logic                 pressed_low_ff;
   logic [REG_WIDTH-1:0] debounce_time_ff;
   logic [REG_WIDTH-1:0] long_press_time_ff;
   logic [REG_WIDTH-1:0] repeat_interval_ff;
   logic                 wr_en;
   logic [2:0]           reg_index;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign reg_index  = csr_paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff         <= 1'b0;
         pressed_low_ff     <= 1'b1;
         debounce_time_ff   <= REG_WIDTH'(20);
         long_press_time_ff <= REG_WIDTH'(1000);
         repeat_interval_ff <= '0;
      end else if (wr_en) begin
         case (reg_index)
            REG_ENABLED:         enabled_ff         <= csr_pwdata[0];
            REG_PRESSED_LOW:     pressed_low_ff     <= csr_pwdata[0];
            REG_DEBOUNCE_TIME:   debounce_time_ff   <= csr_pwdata[REG_WIDTH-1:0];
            REG_LONG_PRESS_TIME: long_press_time_ff <= csr_pwdata[REG_WIDTH-1:0];
            REG_REPEAT_INTERVAL: repeat_interval_ff <= csr_pwdata[REG_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         REG_ENABLED:         csr_prdata = CSR_DATA_WIDTH'(enabled_ff);
         REG_PRESSED_LOW:     csr_prdata = CSR_DATA_WIDTH'(pressed_low_ff);
         REG_DEBOUNCE_TIME:   csr_prdata = CSR_DATA_WIDTH'(debounce_time_ff);
         REG_LONG_PRESS_TIME: csr_prdata = CSR_DATA_WIDTH'(long_press_time_ff);
         REG_REPEAT_INTERVAL: csr_prdata = CSR_DATA_WIDTH'(repeat_interval_ff);
         default:             csr_prdata = '0;
      endcase
   end

   always_comb begin
      cfg.enabled         = enabled_ff;
      cfg.pressed_low     = pressed_low_ff;
      cfg.debounce_time   = debounce_time_ff;
      cfg.long_press_time = long_press_time_ff;
      cfg.repeat_interval = repeat_interval_ff;
      // restart the phase machine when enabling
      cfg.restart         = wr_en & (reg_index == REG_ENABLED) & ~enabled_ff
                            & csr_pwdata[0];
   end

endmodule

// File: rtl/btn_dbnc_fsm.sv
// ----------------------------------------------------------------------------
// btn_dbnc_fsm
// Phase machine and timestamps; computes one poll's event per advance.
// ----------------------------------------------------------------------------
module btn_dbnc_fsm
   import btn_dbnc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  logic        advance,
   input  logic        pin_level,
   input  logic [31:0] time_now,
   output logic [2:0]  event_code,
   output logic        is_pressed
);

   logic [1:0]            phase_ff, phase_in;
   logic [TIME_WIDTH-1:0] debounce_start_ff, debounce_start_in;
   logic [TIME_WIDTH-1:0] press_start_ff, press_start_in;
   logic [TIME_WIDTH-1:0] last_repeat_ff, last_repeat_in;
   logic                  pressed_flag_ff, pressed_flag_in;

   logic                  raw;
   logic [TIME_WIDTH-1:0] now;
   logic [TIME_WIDTH-1:0] deb_elapsed, press_elapsed, rep_elapsed;
   logic                  deb_done, long_done, rep_due;

   assign now           = TIME_WIDTH'(time_now);
   assign raw           = cfg.pressed_low ? ~pin_level : pin_level;
   assign deb_elapsed   = now - debounce_start_ff;
   assign press_elapsed = now - press_start_ff;
   assign rep_elapsed   = now - last_repeat_ff;
   assign deb_done  = CMP_WIDTH'(deb_elapsed) >= CMP_WIDTH'(cfg.debounce_time);
   assign long_done = CMP_WIDTH'(press_elapsed) >= CMP_WIDTH'(cfg.long_press_time);
   assign rep_due   = (cfg.repeat_interval != '0) &&
                      (CMP_WIDTH'(rep_elapsed) >= CMP_WIDTH'(cfg.repeat_interval));

   always_comb begin
      phase_in          = phase_ff;
      debounce_start_in = debounce_start_ff;
      press_start_in    = press_start_ff;
      last_repeat_in    = last_repeat_ff;
      pressed_flag_in   = pressed_flag_ff;
      event_code        = EV_NONE;
      if (cfg.enabled) begin
         case (phase_ff)
            PH_IDLE: begin
               if (raw) begin
                  phase_in          = PH_DEB;
                  debounce_start_in = now;
               end
            end
            PH_DEB: begin
               if (!raw) begin
                  phase_in = PH_IDLE;
               end else if (deb_done) begin
                  phase_in        = PH_PRESS;
                  pressed_flag_in = 1'b1;
                  press_start_in  = now;
                  last_repeat_in  = now;
                  event_code      = EV_DOWN;
               end
            end
            PH_PRESS: begin
               if (!raw) begin
                  phase_in        = PH_IDLE;
                  pressed_flag_in = 1'b0;
                  event_code      = EV_CLICK;
               end else if (long_done) begin
                  phase_in       = PH_LONG;
                  last_repeat_in = now;
                  event_code     = EV_LONG;
               end
            end
            default: begin
               if (!raw) begin
                  phase_in        = PH_IDLE;
                  pressed_flag_in = 1'b0;
                  event_code      = EV_UP;
               end else if (rep_due) begin
                  last_repeat_in = now;
                  event_code     = EV_REPEAT;
               end
            end
         endcase
      end
      is_pressed = pressed_flag_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff          <= PH_IDLE;
         pressed_flag_ff   <= 1'b0;
         debounce_start_ff <= '0;
         press_start_ff    <= '0;
         last_repeat_ff    <= '0;
      end else if (cfg.restart) begin
         // keep the timestamps
         phase_ff        <= PH_IDLE;
         pressed_flag_ff <= 1'b0;
      end else if (advance) begin
         phase_ff          <= phase_in;
         pressed_flag_ff   <= pressed_flag_in;
         debounce_start_ff <= debounce_start_in;
         press_start_ff    <= press_start_in;
         last_repeat_ff    <= last_repeat_in;
      end
   end

endmodule

// File: rtl/button_debounce_long_press_repeat_core.sv
// An accepted req word passes through the input register, then the result register,
// to its rsp word; exactly one rsp word per req word.
// Throughput: one word per cycle unless rsp_tready stalls; the phase machine updates
// in the same cycle that a word moves from the input register to the result register.
// Reset: synchronous, active high; clears both register valids, the phase
// machine and timestamps, and loads the configuration reset values.
// ----------------------------------------------------------------------------
// button_debounce_long_press_repeat_core
// Push-button debouncer with down, click, long-press, repeat and up events.
// ----------------------------------------------------------------------------
module button_debounce_long_press_repeat_core
   import btn_dbnc_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   // req: [0] pin_level, [32:1] time_now, [39:33] zero
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [39:0]               req_tdata,
   // rsp: [2:0] event_code, [3] is_pressed, [7:4] zero
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [7:0]                rsp_tdata,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                      csr_pready
);

   cfg_type     cfg;
   logic        in_valid_ff;
   logic        pin_level_ff;
   logic [31:0] time_now_ff;
   logic        rsp_valid_ff;
   logic [2:0]  event_code_ff;
   logic        is_pressed_ff;
   logic        advance;
   logic [2:0]  event_code_in;
   logic        is_pressed_in;

   btn_dbnc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   btn_dbnc_fsm u_fsm (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .advance    (advance),
      .pin_level  (pin_level_ff),
      .time_now   (time_now_ff),
      .event_code (event_code_in),
      .is_pressed (is_pressed_in)
   );

   // move a word on when the result register is free or being emptied
   assign advance    = in_valid_ff & (~rsp_valid_ff | rsp_tready);
   assign req_tready = ~in_valid_ff | advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready & req_tvalid) begin
         pin_level_ff <= req_tdata[0];
         time_now_ff  <= req_tdata[32:1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         event_code_ff <= event_code_in;
         is_pressed_ff <= is_pressed_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, is_pressed_ff, event_code_ff};

`ifndef SYNTH
   a_down_pressed: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tdata[2:0] == EV_DOWN)) |-> rsp_tdata[3])
      else $error("down event without pressed flag");

   a_release_clear: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && ((rsp_tdata[2:0] == EV_CLICK) || (rsp_tdata[2:0] == EV_UP)))
         |-> !rsp_tdata[3])
      else $error("release event with pressed flag set");

   a_code_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[2:0] <= EV_REPEAT))
      else $error("event code out of range");

   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff |-> req_tready)
      else $error("input stalled with empty result register");
`endif

endmodule

// File: verif/tb_button_debounce_long_press_repeat_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_button_debounce_long_press_repeat_core
// Self-checking bench for the button debouncer. A directed table covers
// threshold edges, time wrap, repeats and enable handling. Random press
// sequences with contact bounce and noise follow under varied settings.
// Each rsp word is checked against a typed row's want or a local phase machine model.
// ----------------------------------------------------------------------------
module tb_button_debounce_long_press_repeat_core;
   import btn_dbnc_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int N_DIRECTED  = 31;

   typedef struct packed {
      logic [2:0] event_code;
      logic       is_pressed;
   } poll_result_type;

   typedef enum logic {ROW_POLL, ROW_CSR} row_kind_type;

   // poll row: arg = pin level, value = time; csr row: arg = register, value = data
   typedef struct packed {
      row_kind_type    kind;
      logic [31:0]     arg;
      logic [31:0]     value;
      logic            typed;
      poll_result_type want;
   } stim_row_type;

   logic                      clock       = 1'b0;
   logic                      reset       = 1'b1;
   logic                      req_tvalid  = 1'b0;
   logic                      req_tready;
   // [0] pin_level, [32:1] time_now, [39:33] zero
   logic [39:0]               req_tdata   = '0;
   logic                      rsp_tvalid;
   logic                      rsp_tready  = 1'b0;
   // [2:0] event_code, [3] is_pressed, [7:4] zero
   logic [7:0]                rsp_tdata;
   logic                      csr_psel    = 1'b0;
   logic                      csr_penable = 1'b0;
   logic                      csr_pwrite  = 1'b0;
   logic [CSR_ADDR_WIDTH-1:0] csr_paddr   = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_prdata;
   logic                      csr_pready;

   // register copies, reset values
   logic                  cfg_enabled         = 1'b0;
   logic                  cfg_pressed_low     = 1'b1;
   logic [REG_WIDTH-1:0]  cfg_debounce_time   = 32'd20;
   logic [REG_WIDTH-1:0]  cfg_long_press_time = 32'd1000;
   logic [REG_WIDTH-1:0]  cfg_repeat_interval = 32'd0;

   // phase machine copy
   logic [1:0]            dbn_phase          = PH_IDLE;
   logic [TIME_WIDTH-1:0] dbn_debounce_start = '0;
   logic [TIME_WIDTH-1:0] dbn_press_start    = '0;
   logic [TIME_WIDTH-1:0] dbn_last_repeat    = '0;
   logic                  dbn_pressed        = 1'b0;

   poll_result_type pending_events[$];
   poll_result_type got_word;
   poll_result_type want_word;
   int           mismatch_count = 0;
   int           cycle_count    = 0;
   int           req_calm       = 0;
   int           rsp_calm       = 0;
   int           rsp_gap;
   logic         rsp_taken;

   stim_row_type directed_rows [N_DIRECTED] = '{
      '{ROW_POLL, 32'd0, 32'd0,          1'b1, '{EV_NONE,   1'b0}},
      '{ROW_POLL, 32'd1, 32'hFFFF_FFFF,  1'b1, '{EV_NONE,   1'b0}},
      '{ROW_CSR,  32'(REG_ENABLED), 32'd1,        1'b0, '{EV_NONE, 1'b0}},
      '{ROW_POLL, 32'd0, 32'd100,        1'b0, '{EV_NONE,   1'b0}},
      '{ROW_POLL, 32'd1, 32'd105,        1'b0, '{EV_NONE,   1'b0}},
      '{ROW_POLL, 32'd0, 32'd200,        1'b0, '{EV_NONE,   1'b0}},
      '{ROW_POLL, 32'd0, 32'd219,        1'b0, '{EV_NONE,   1'b0}},
      '{ROW_POLL, 32'd0, 32'd220,        1'b1, '{EV_DOWN,   1'b1}},
      '{ROW_POLL, 32'd1, 32'd230,        1'b1, '{EV_CLICK,  1'b0}},
      '{ROW_CSR,  32'(REG_DEBOUNCE_TIME), 32'd0,  1'b0, '{EV_NONE, 1'b0}},
      '{ROW_POLL, 32'd0, 32'hFFFF_FFF0,  1'b0, '{EV_NONE,   1'b0}},
      '{ROW_POLL, 32'd0, 32'hFFFF_FFF0,  1'b1, '{EV_DOWN,   1'b1}},
      '{ROW_POLL, 32'd0, 32'h0000_03D7,  1'b0, '{EV_NONE,   1'b0}},
      '{ROW_POLL, 32'd0, 32'h0000_03D8,  1'b1, '{EV_LONG,   1'b1}},
      '{ROW_POLL, 32'd0, 32'h7FFF_FFFF,  1'b0, '{EV_NONE,   1'b0}},
      '{ROW_POLL, 32'd1, 32'h8000_0000,  1'b1, '{EV_UP,     1'b0}},
      '{ROW_CSR,  32'(REG_PRESSED_LOW), 32'd0,    1'b0, '{EV_NONE, 1'b0}},
      '{ROW_CSR,  32'(REG_LONG_PRESS_TIME), 32'd0, 1'b0, '{EV_NONE, 1'b0}},
      '{ROW_CSR,  32'(REG_REPEAT_INTERVAL), 32'hFFFF_FFFF, 1'b0, '{EV_NONE, 1'b0}},
      '{ROW_POLL, 32'd1, 32'd10,         1'b0, '{EV_NONE,   1'b0}},
      '{ROW_POLL, 32'd1, 32'd10,         1'b0, '{EV_NONE,   1'b0}},
      '{ROW_POLL, 32'd1, 32'd10,         1'b0, '{EV_NONE,   1'b0}},
      '{ROW_POLL, 32'd1, 32'd9,          1'b1, '{EV_REPEAT, 1'b1}},
      '{ROW_CSR,  32'(REG_ENABLED), 32'hFFFF_FFFE, 1'b0, '{EV_NONE, 1'b0}},
      '{ROW_POLL, 32'd0, 32'd20,         1'b1, '{EV_NONE,   1'b1}},
      '{ROW_CSR,  32'(REG_ENABLED), 32'd1,        1'b0, '{EV_NONE, 1'b0}},
      '{ROW_POLL, 32'd0, 32'd30,         1'b1, '{EV_NONE,   1'b0}},
      '{ROW_CSR,  32'(REG_DEBOUNCE_TIME), 32'hFFFF_FFFF, 1'b0, '{EV_NONE, 1'b0}},
      '{ROW_POLL, 32'd1, 32'd40,         1'b0, '{EV_NONE,   1'b0}},
      '{ROW_POLL, 32'd1, 32'd39,         1'b1, '{EV_DOWN,   1'b1}},
      '{ROW_POLL, 32'd0, 32'd50,         1'b0, '{EV_NONE,   1'b0}}
   };

   button_debounce_long_press_repeat_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // Advance the phase machine by one poll and return the event it reports.
   function automatic poll_result_type debounce_step(logic level,
                                                     logic [TIME_WIDTH-1:0] now);
      logic                  raw;
      logic [TIME_WIDTH-1:0] elapsed;
      poll_result_type       r;
      raw = cfg_pressed_low ? ~level : level;
      r.event_code = EV_NONE;
      if (cfg_enabled) begin
         case (dbn_phase)
            PH_IDLE: begin
               if (raw) begin
                  dbn_phase = PH_DEB;
                  dbn_debounce_start = now;
               end
            end
            PH_DEB: begin
               elapsed = now - dbn_debounce_start;
               if (!raw) begin
                  dbn_phase = PH_IDLE;
               end else if (elapsed >= cfg_debounce_time) begin
                  dbn_phase = PH_PRESS;
                  dbn_pressed = 1'b1;
                  dbn_press_start = now;
                  dbn_last_repeat = now;
                  r.event_code = EV_DOWN;
               end
            end
            PH_PRESS: begin
               elapsed = now - dbn_press_start;
               if (!raw) begin
                  dbn_phase = PH_IDLE;
                  dbn_pressed = 1'b0;
                  r.event_code = EV_CLICK;
               end else if (elapsed >= cfg_long_press_time) begin
                  dbn_phase = PH_LONG;
                  dbn_last_repeat = now;
                  r.event_code = EV_LONG;
               end
            end
            default: begin
               elapsed = now - dbn_last_repeat;
               if (!raw) begin
                  dbn_phase = PH_IDLE;
                  dbn_pressed = 1'b0;
                  r.event_code = EV_UP;
               end else if (cfg_repeat_interval != 0 && elapsed >= cfg_repeat_interval) begin
                  dbn_last_repeat = now;
                  r.event_code = EV_REPEAT;
               end
            end
         endcase
      end
      r.is_pressed = dbn_pressed;
      return r;
   endfunction

   function automatic void apply_csr(logic [2:0] idx, logic [31:0] value);
      case (idx)
         REG_ENABLED: begin
            // rising enable restarts the machine but keeps the timestamps
            if (!cfg_enabled && value[0]) begin
               dbn_phase = PH_IDLE;
               dbn_pressed = 1'b0;
            end
            cfg_enabled = value[0];
         end
         REG_PRESSED_LOW:     cfg_pressed_low = value[0];
         REG_DEBOUNCE_TIME:   cfg_debounce_time = value;
         REG_LONG_PRESS_TIME: cfg_long_press_time = value;
         REG_REPEAT_INTERVAL: cfg_repeat_interval = value;
         default: ;
      endcase
   endfunction

   // Idle cycles before the next word; now and then hold a stretch with none.
   function automatic int idle_gap(inout int calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(19, 0) == 0) calm = $urandom_range(60, 10);
      return $urandom_range(13, 0);
   endfunction

   function automatic logic [31:0] draw_threshold(int hi);
      case ($urandom_range(9, 0))
         0:       return 32'd0;
         1:       return 32'hFFFF_FFFF;
         2:       return $urandom();
         default: return $urandom_range(hi, 1);
      endcase
   endfunction

   function automatic void report_mismatch(string what, poll_result_type want,
                                           poll_result_type got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("%s: expected event %0d pressed %0b, got event %0d pressed %0b",
                  what, want.event_code, want.is_pressed, got.event_code, got.is_pressed);
   endfunction

   task automatic send_poll(logic level, logic [31:0] now, logic typed,
                            poll_result_type want);
      int   gap;
      logic taken;
      gap = idle_gap(req_calm);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {7'd0, now, level};
      do begin
         @(negedge clock);
         taken = req_tready;
         @(posedge clock);
      end while (!taken);
      if (typed) begin
         void'(debounce_step(level, TIME_WIDTH'(now)));
         pending_events.push_back(want);
      end else begin
         pending_events.push_back(debounce_step(level, TIME_WIDTH'(now)));
      end
   endtask

   task automatic csr_write(logic [2:0] idx, logic [31:0] value);
      logic ready;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do begin
         @(negedge clock);
         ready = csr_pready;
         @(posedge clock);
      end while (!ready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      apply_csr(idx, value);
      // leave the bus idle before the next transfer
      @(posedge clock);
   endtask

   // Drop valid, drain every pending word, then let the pipeline settle.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (pending_events.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // rsp side: stall at random, then hold ready until one word moves
   initial begin
      do @(negedge clock); while (reset);
      @(posedge clock);
      forever begin
         rsp_gap = idle_gap(rsp_calm);
         if (rsp_gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (rsp_gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do begin
            @(negedge clock);
            rsp_taken = rsp_tvalid;
            @(posedge clock);
         end while (!rsp_taken);
      end
   end

   // Inputs are steady from the falling edge on, so a word seen here moves at the next rise.
   always @(negedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_word.event_code = rsp_tdata[2:0];
         got_word.is_pressed = rsp_tdata[3];
         if (pending_events.size() == 0) begin
            report_mismatch("word with nothing pending", '0, got_word);
         end else begin
            want_word = pending_events.pop_front();
            if (got_word.event_code !== want_word.event_code ||
                got_word.is_pressed !== want_word.is_pressed)
               report_mismatch("event mismatch", want_word, got_word);
         end
      end
   end

   initial begin
      int          i;
      int          ph;
      int          sent;
      int          phase_len;
      int          n_bounce;
      int          n_hold;
      int          n_mid;
      int          n_rel;
      int          step;
      logic        press_lvl;
      logic [31:0] ms;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      for (i = 0; i < N_DIRECTED; i++) begin
         if (directed_rows[i].kind == ROW_CSR) begin
            wait_idle();
            csr_write(directed_rows[i].arg[2:0], directed_rows[i].value);
         end else begin
            send_poll(directed_rows[i].arg[0], directed_rows[i].value,
                      directed_rows[i].typed, directed_rows[i].want);
         end
      end

      ms = $urandom();
      for (ph = 0; ph < 16; ph++) begin
         wait_idle();
         if (ph == 0 || $urandom_range(1, 0)) csr_write(REG_PRESSED_LOW, $urandom());
         if (ph == 0 || $urandom_range(1, 0)) csr_write(REG_DEBOUNCE_TIME, draw_threshold(30));
         if (ph == 0 || $urandom_range(1, 0))
            csr_write(REG_LONG_PRESS_TIME, draw_threshold(60));
         if (ph == 0 || $urandom_range(1, 0))
            csr_write(REG_REPEAT_INTERVAL,
                      ($urandom_range(3, 0) == 0) ? 32'd0 : draw_threshold(20));
         if (ph == 0)
            csr_write(REG_ENABLED, 32'd1);
         else if ($urandom_range(3, 0) == 0)
            csr_write(REG_ENABLED, ($urandom() & 32'hFFFF_FFFE) |
                                   32'($urandom_range(7, 0) != 0));
         // start some phases just short of the time wrap
         if ($urandom_range(3, 0) == 0) ms = 32'hFFFF_FFFF - $urandom_range(200, 0);

         phase_len = cfg_enabled ? 85 : 30;
         sent = 0;
         while (sent < phase_len) begin
            press_lvl = ~cfg_pressed_low;
            if ($urandom_range(9, 0) == 0) begin
               send_poll(1'($urandom_range(1, 0)), $urandom(), 1'b0, '0);
               sent++;
            end else begin
               n_bounce = $urandom_range(4, 0);
               n_hold   = $urandom_range(40, 1);
               n_mid    = $urandom_range(3, 0);
               n_rel    = $urandom_range(6, 1);
               step     = $urandom_range(8, 0);
               repeat (n_bounce) begin
                  ms += $urandom_range(3, 0);
                  send_poll(1'($urandom_range(1, 0)), ms, 1'b0, '0);
               end
               repeat (n_hold) begin
                  ms += $urandom_range(step, 0);
                  send_poll(press_lvl, ms, 1'b0, '0);
               end
               repeat (n_mid) begin
                  ms += $urandom_range(3, 0);
                  send_poll(1'($urandom_range(1, 0)), ms, 1'b0, '0);
               end
               repeat (n_rel) begin
                  ms += $urandom_range(step, 0);
                  send_poll(~press_lvl, ms, 1'b0, '0);
               end
               sent += n_bounce + n_hold + n_mid + n_rel;
            end
         end
      end

      wait_idle();
      if (mismatch_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

// File: filelist.f
rtl/btn_dbnc_pkg.sv
rtl/btn_dbnc_csr.sv
rtl/btn_dbnc_fsm.sv
rtl/button_debounce_long_press_repeat_core.sv
verif/tb_button_debounce_long_press_repeat_core.sv
